>>> rtl/bale_pkg.sv
// Shared constants, types and control structs of the byte list editor.
package bale_pkg;

   localparam int CAPACITY  = 64;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int LEN_W     = $clog2(CAPACITY + 1);
   localparam int MODE_W    = 2;
   localparam int POS_W     = 6;
   localparam int BYTE_W    = 8;
   localparam int STATUS_W  = 2;
   localparam int LEN_NOW_W = 7;
   localparam int CMP_W     = (LEN_W > POS_W) ? LEN_W : POS_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_GET    = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_INSERT = 2'd2,
      MODE_ERASE  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_GET,
      S_APPEND,
      S_INS_RD,
      S_INS_WR,
      S_ERS_RD,
      S_ERS_WR,
      S_FIN
   } state_type;

   typedef enum logic [2:0] {
      ASEL_POS,
      ASEL_LEN,
      ASEL_IDX,
      ASEL_IDX_M1,
      ASEL_IDX_P1
   } addr_sel_type;

   typedef struct packed {
      logic         load;
      logic         rd_en;
      addr_sel_type rd_sel;
      logic         wr_en;
      addr_sel_type wr_sel;
      logic         wr_from_ram;
      logic         idx_dec;
      logic         idx_inc;
      logic         len_inc;
      logic         len_dec;
      logic         rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      status_type req_status;
      logic       ins_more;
      logic       ers_more;
      logic       slot_free;
   } dp_stat_type;

endpackage

>>> rtl/bale_ram.sv
// Generic single write port, single read port RAM with registered read data.
module bale_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bale_ctrl.sv
// Controller state machine that sequences each command over the list datapath.
module bale_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  bale_pkg::mode_type     req_mode,
   input  bale_pkg::dp_stat_type  stat,
   output logic                   req_ready,
   output bale_pkg::ctrl_cmd_type cmd
);

   bale_pkg::state_type state_ff;
   bale_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bale_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         bale_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (stat.req_status != bale_pkg::STATUS_OK) begin
                  state_in = bale_pkg::S_FIN;
               end else begin
                  unique case (req_mode)
                     bale_pkg::MODE_GET:    state_in = bale_pkg::S_GET;
                     bale_pkg::MODE_APPEND: state_in = bale_pkg::S_APPEND;
                     bale_pkg::MODE_INSERT: state_in = bale_pkg::S_INS_RD;
                     bale_pkg::MODE_ERASE:  state_in = bale_pkg::S_ERS_RD;
                     default:               state_in = bale_pkg::S_FIN;
                  endcase
               end
            end
         end
         bale_pkg::S_GET: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = bale_pkg::ASEL_POS;
            state_in   = bale_pkg::S_FIN;
         end
         bale_pkg::S_APPEND: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = bale_pkg::ASEL_LEN;
            cmd.len_inc = 1'b1;
            state_in    = bale_pkg::S_FIN;
         end
         bale_pkg::S_INS_RD: begin
            // Walk down from the end, moving each entry one place up.
            if (stat.ins_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bale_pkg::ASEL_IDX_M1;
               state_in   = bale_pkg::S_INS_WR;
            end else begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = bale_pkg::ASEL_POS;
               cmd.len_inc = 1'b1;
               state_in    = bale_pkg::S_FIN;
            end
         end
         bale_pkg::S_INS_WR: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_sel      = bale_pkg::ASEL_IDX;
            cmd.wr_from_ram = 1'b1;
            cmd.idx_dec     = 1'b1;
            state_in        = bale_pkg::S_INS_RD;
         end
         bale_pkg::S_ERS_RD: begin
            // Walk up from the erased position, moving each entry one place down.
            if (stat.ers_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bale_pkg::ASEL_IDX_P1;
               state_in   = bale_pkg::S_ERS_WR;
            end else begin
               cmd.len_dec = 1'b1;
               state_in    = bale_pkg::S_FIN;
            end
         end
         bale_pkg::S_ERS_WR: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_sel      = bale_pkg::ASEL_IDX;
            cmd.wr_from_ram = 1'b1;
            cmd.idx_inc     = 1'b1;
            state_in        = bale_pkg::S_ERS_RD;
         end
         bale_pkg::S_FIN: begin
            if (stat.slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = bale_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bale_pkg::S_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/bale_dp.sv
// Datapath: entry RAM, length and index counters, status check and result register.
module bale_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [bale_pkg::MODE_W-1:0]      req_mode,
   input  logic [bale_pkg::POS_W-1:0]       req_position,
   input  logic [bale_pkg::BYTE_W-1:0]      req_in_byte,
   input  bale_pkg::ctrl_cmd_type           cmd,
   output bale_pkg::dp_stat_type            stat,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [bale_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic [bale_pkg::STATUS_W-1:0]    rsp_status,
   output logic [bale_pkg::LEN_NOW_W-1:0]   rsp_length_now
);

   localparam int LW = bale_pkg::LEN_W;
   localparam int AW = bale_pkg::ADDR_W;
   localparam int CW = bale_pkg::CMP_W;
   localparam logic [LW-1:0] CAP_LEN = LW'(bale_pkg::CAPACITY);

   logic [LW-1:0]                   len_ff, len_in;
   logic [LW-1:0]                   idx_ff, idx_in;
   bale_pkg::mode_type              mode_ff, mode_in;
   logic [bale_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [bale_pkg::BYTE_W-1:0]     byte_ff, byte_in;
   bale_pkg::status_type            status_ff, status_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bale_pkg::BYTE_W-1:0]     out_byte_ff, out_byte_in;
   logic [bale_pkg::STATUS_W-1:0]   out_status_ff, out_status_in;
   logic [bale_pkg::LEN_NOW_W-1:0]  out_len_ff, out_len_in;

   bale_pkg::status_type            req_status;
   bale_pkg::mode_type              req_mode_e;
   logic [CW-1:0]                   req_pos_cmp, len_cmp;
   logic [LW-1:0]                   pos_len, idx_m1, idx_p1;
   logic [AW-1:0]                   rd_addr, wr_addr;
   logic [bale_pkg::BYTE_W-1:0]     wr_data, ram_rd;

   function automatic logic [AW-1:0] sel_addr(
      input bale_pkg::addr_sel_type sel,
      input logic [LW-1:0]          p,
      input logic [LW-1:0]          l,
      input logic [LW-1:0]          i,
      input logic [LW-1:0]          im1,
      input logic [LW-1:0]          ip1
   );
      logic [LW-1:0] a;
      unique case (sel)
         bale_pkg::ASEL_POS:    a = p;
         bale_pkg::ASEL_LEN:    a = l;
         bale_pkg::ASEL_IDX:    a = i;
         bale_pkg::ASEL_IDX_M1: a = im1;
         bale_pkg::ASEL_IDX_P1: a = ip1;
         default:               a = i;
      endcase
      return a[AW-1:0];
   endfunction

   // Range and capacity check of the incoming transaction against the current length.
   assign req_mode_e  = bale_pkg::mode_type'(req_mode);
   assign req_pos_cmp = CW'(req_position);
   assign len_cmp     = CW'(len_ff);

   always_comb begin
      req_status = bale_pkg::STATUS_OK;
      unique case (req_mode_e)
         bale_pkg::MODE_GET: begin
            if (req_pos_cmp >= len_cmp) req_status = bale_pkg::STATUS_RANGE;
         end
         bale_pkg::MODE_APPEND: begin
            if (len_ff >= CAP_LEN) req_status = bale_pkg::STATUS_FULL;
         end
         bale_pkg::MODE_INSERT: begin
            if (req_pos_cmp > len_cmp) begin
               req_status = bale_pkg::STATUS_RANGE;
            end else if (len_ff >= CAP_LEN) begin
               req_status = bale_pkg::STATUS_FULL;
            end
         end
         bale_pkg::MODE_ERASE: begin
            if (req_pos_cmp >= len_cmp) req_status = bale_pkg::STATUS_RANGE;
         end
         default: req_status = bale_pkg::STATUS_OK;
      endcase
   end

   assign pos_len = LW'(pos_ff);
   assign idx_m1  = idx_ff - LW'(1);
   assign idx_p1  = idx_ff + LW'(1);

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      byte_in   = byte_ff;
      status_in = status_ff;
      idx_in    = idx_ff;
      len_in    = len_ff;
      if (cmd.load) begin
         mode_in   = req_mode_e;
         pos_in    = req_position;
         byte_in   = req_in_byte;
         status_in = req_status;
         // Insert walks down from the end; erase walks up from the position.
         idx_in    = (req_mode_e == bale_pkg::MODE_INSERT) ? len_ff : LW'(req_position);
      end else if (cmd.idx_dec) begin
         idx_in = idx_m1;
      end else if (cmd.idx_inc) begin
         idx_in = idx_p1;
      end
      if (cmd.len_inc) begin
         len_in = len_ff + LW'(1);
      end else if (cmd.len_dec) begin
         len_in = len_ff - LW'(1);
      end
   end

   assign rd_addr = sel_addr(cmd.rd_sel, pos_len, len_ff, idx_ff, idx_m1, idx_p1);
   assign wr_addr = sel_addr(cmd.wr_sel, pos_len, len_ff, idx_ff, idx_m1, idx_p1);
   assign wr_data = cmd.wr_from_ram ? ram_rd : byte_ff;

   bale_ram #(
      .WIDTH(bale_pkg::BYTE_W),
      .DEPTH(bale_pkg::CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      out_byte_in   = out_byte_ff;
      out_status_in = out_status_ff;
      out_len_in    = out_len_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         // The read data of a get is still held by the RAM output register here.
         out_byte_in   = (mode_ff == bale_pkg::MODE_GET && status_ff == bale_pkg::STATUS_OK)
                         ? ram_rd : '0;
         out_status_in = status_ff;
         out_len_in    = bale_pkg::LEN_NOW_W'(len_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      pos_ff        <= pos_in;
      byte_ff       <= byte_in;
      status_ff     <= status_in;
      idx_ff        <= idx_in;
      out_byte_ff   <= out_byte_in;
      out_status_ff <= out_status_in;
      out_len_ff    <= out_len_in;
   end

   assign stat.req_status = req_status;
   assign stat.ins_more   = (idx_ff > pos_len);
   assign stat.ers_more   = ((LW + 1)'(idx_ff) + (LW + 1)'(1)) < (LW + 1)'(len_ff);
   assign stat.slot_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_length_now = out_len_ff;

endmodule

>>> rtl/byte_array_list_edit.sv
// Top level of the ordered byte list with get, append, insert and erase commands.
//
//   Channel | Ports                                        | Direction
//   req     | req_valid/ready, mode, position, in_byte     | in
//   rsp     | rsp_valid/ready, out_byte, status, length_now| out
//
// One command is handled at a time; a command that fails its check goes straight to
// the result. Insert and erase shift the list tail one entry at a time through the
// single entry RAM (read, then write with registered read data). The result register
// lets the next command be accepted while a result waits; a command stalls in its
// last cycle only while the previous result is still untaken. Reset empties the
// list at once.
module byte_array_list_edit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bale_pkg::MODE_W-1:0]        req_mode,
   input  logic [bale_pkg::POS_W-1:0]         req_position,
   input  logic [bale_pkg::BYTE_W-1:0]        req_in_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bale_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic [bale_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bale_pkg::LEN_NOW_W-1:0]     rsp_length_now
);

   bale_pkg::ctrl_cmd_type cmd;
   bale_pkg::dp_stat_type  stat;

   bale_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (bale_pkg::mode_type'(req_mode)),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   bale_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_mode),
      .req_position   (req_position),
      .req_in_byte    (req_in_byte),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_status     (rsp_status),
      .rsp_length_now (rsp_length_now)
   );

   // Only one transaction is in flight: after an accept the input side closes.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a command is still running");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_length_now) <= bale_pkg::CAPACITY))
      else $error("reported length exceeds capacity");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bale_pkg::STATUS_FULL
      |-> 32'(rsp_length_now) == bale_pkg::CAPACITY)
      else $error("list full reported below capacity");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bale_pkg::STATUS_OK |-> rsp_out_byte == '0)
      else $error("nonzero byte returned with an error status");

endmodule
